/* rtl/rlpm_pkg.sv */
package rlpm_pkg;

    // default table depth
    localparam int ENTRIES_DEF = 16;

    // fixed field widths
    localparam int IDX_W    = 4;
    localparam int IP_W     = 32;
    localparam int PORT_W   = 2;
    localparam int PLEN_W   = 6;
    localparam int IN_W     = 136;
    localparam int OUT_W    = 48;

    // request kinds carried on the input tuser bit
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } rlpm_state_t;

    // one stored route, prefix length precomputed at write time
    typedef struct packed {
        logic [IP_W-1:0]   dest;
        logic [IP_W-1:0]   mask;
        logic [IP_W-1:0]   gateway;
        logic [PORT_W-1:0] port;
        logic [PLEN_W-1:0] plen;
    } rlpm_entry_t;

    // write port of the route table
    typedef struct packed {
        logic        en;
        logic        valid;
        rlpm_entry_t entry;
    } rlpm_wr_t;

endpackage

/* rtl/rlpm_table.sv */
module rlpm_table #(
    parameter int ENTRIES = rlpm_pkg::ENTRIES_DEF,
    parameter int AW      = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rlpm_pkg::rlpm_wr_t    wr,
    input  logic [AW-1:0]         wr_addr,
    input  logic [AW-1:0]         rd_addr,
    output rlpm_pkg::rlpm_entry_t rd_entry,
    output logic                  rd_valid
);

    rlpm_pkg::rlpm_entry_t mem [0:ENTRIES-1];
    logic [ENTRIES-1:0]    valid_reg;
    rlpm_pkg::rlpm_entry_t rd_entry_reg;
    logic                  rd_valid_reg;

    // route payload, no reset
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    // per-slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr_addr] <= wr.valid;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

/* rtl/route_longest_prefix_match_core.sv */
// ipv4 longest prefix match route table
//
// input channel s_axis_*: one request per handshake. tuser selects the kind:
// a write loads one route slot, a lookup searches the table for an address.
// output channel m_axis_*: exactly one result per request, in request order.
// a write returns an all-zero result, a miss returns an all-zero result.
//
// a write goes from its accept straight to the finish step. a lookup reads one
// slot per cycle from the route memory into a single shared match and compare
// unit, then offers its result from the finish step.
// s_axis_tready is high only while the sequencer is idle, so a new request is
// not taken until the previous one has left the finish step.
// the prefix length of each route is worked out once, when it is written.
//
// the result sits in an output register: a new request is taken while an
// earlier result still waits, and a finished request holds in its last step
// until the output register frees up when the receiver stalls.
//
// reset clears all slot valid bits, the sequencer and the output register;
// route contents are unknown until written, but only valid slots can match.
module route_longest_prefix_match_core #(
    parameter int ENTRIES = rlpm_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // entry_index, entry_dest, entry_mask, entry_gateway, entry_port,
    // entry_valid, lookup_address, one zero pad bit
    input  logic [rlpm_pkg::IN_W-1:0]   s_axis_tdata,
    // func
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // hit, next_hop, out_port, prefix_length, seven zero pad bits
    output logic [rlpm_pkg::OUT_W-1:0]  m_axis_tdata
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    // prefix length: 32 minus trailing zeros, 0 for a zero mask
    function automatic logic [rlpm_pkg::PLEN_W-1:0] prefix_len(
        input logic [rlpm_pkg::IP_W-1:0] m
    );
        logic [rlpm_pkg::IP_W-1:0] low;
        logic [4:0]                tz;
        low = m & (~m + 32'd1);
        tz  = '0;
        for (int i = 0; i < rlpm_pkg::IP_W; i++)
        begin
            tz = tz | ({5{low[i]}} & 5'(i));
        end
        if (m == '0)
        begin
            prefix_len = '0;
        end
        else
        begin
            prefix_len = 6'd32 - {1'b0, tz};
        end
    endfunction

    rlpm_pkg::rlpm_state_t           state_reg, state_next;
    logic [AW-1:0]                   cnt_reg, cnt_next;
    logic                            eval_reg, eval_next;
    logic [rlpm_pkg::IP_W-1:0]       addr_reg, addr_next;
    logic                            found_reg, found_next;
    logic [rlpm_pkg::PLEN_W-1:0]     best_reg, best_next;
    logic [rlpm_pkg::IP_W-1:0]       hop_reg, hop_next;
    logic [rlpm_pkg::PORT_W-1:0]     port_reg, port_next;
    logic                            out_valid_reg, out_valid_next;
    logic [rlpm_pkg::OUT_W-1:0]      out_data_reg, out_data_next;

    logic                            accept;
    logic                            in_range;
    rlpm_pkg::rlpm_wr_t              wr;
    logic [AW-1:0]                   wr_addr;
    rlpm_pkg::rlpm_entry_t           rd_entry;
    logic                            rd_valid;
    logic                            match;
    logic                            take;

    assign s_axis_tready = (state_reg == rlpm_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // slots at or beyond the table depth are dropped
    assign in_range = ({28'd0, s_axis_tdata[3:0]} < 32'(ENTRIES));

    assign wr.en            = accept && (s_axis_tuser == rlpm_pkg::FUNC_WRITE) && in_range;
    assign wr.valid         = s_axis_tdata[102];
    assign wr.entry.dest    = s_axis_tdata[35:4];
    assign wr.entry.mask    = s_axis_tdata[67:36];
    assign wr.entry.gateway = s_axis_tdata[99:68];
    assign wr.entry.port    = s_axis_tdata[101:100];
    assign wr.entry.plen    = prefix_len(s_axis_tdata[67:36]);
    assign wr_addr          = AW'(s_axis_tdata[3:0]);

    rlpm_table #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .rd_addr  (cnt_reg),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid)
    );

    // shared match unit: one slot per cycle, later slot wins a tie
    assign match = rd_valid && (((addr_reg ^ rd_entry.dest) & rd_entry.mask) == '0);
    assign take  = eval_reg && match && (!found_reg || (rd_entry.plen >= best_reg));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        eval_next      = 1'b0;
        addr_next      = addr_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        hop_next       = hop_reg;
        port_next      = port_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (take)
        begin
            found_next = 1'b1;
            best_next  = rd_entry.plen;
            hop_next   = rd_entry.gateway;
            port_next  = rd_entry.port;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rlpm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    found_next = 1'b0;
                    best_next  = '0;
                    hop_next   = '0;
                    port_next  = '0;
                    addr_next  = s_axis_tdata[134:103];
                    cnt_next   = '0;
                    if (s_axis_tuser == rlpm_pkg::FUNC_LOOKUP)
                    begin
                        state_next = rlpm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = rlpm_pkg::ST_FINISH;
                    end
                end
            end
            rlpm_pkg::ST_SCAN:
            begin
                eval_next = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = rlpm_pkg::ST_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            rlpm_pkg::ST_LAST:
            begin
                // last slot is being compared this cycle
                state_next = rlpm_pkg::ST_FINISH;
            end
            rlpm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, best_reg, port_reg, hop_reg, found_reg};
                    state_next     = rlpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rlpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rlpm_pkg::ST_IDLE;
            cnt_reg       <= '0;
            eval_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            eval_reg      <= eval_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        best_reg     <= best_next;
        hop_reg      <= hop_next;
        port_reg     <= port_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* bench/tb_route_longest_prefix_match_core.sv */
`timescale 1ns / 100ps

module tb_route_longest_prefix_match_core;

    import rlpm_pkg::*;

    localparam int ENTRIES   = ENTRIES_DEF;
    localparam int RANDOM_N  = 1030;
    localparam int DRAIN_CYC = ENTRIES + 12;

    // one result as it travels on m_axis_tdata, highest field first
    typedef struct packed {
        logic [PLEN_W-1:0] prefix_length;
        logic [PORT_W-1:0] out_port;
        logic [IP_W-1:0]   next_hop;
        logic              hit;
    } route_result_t;

    // own copy of the route table plus the queue of results still owed
    class route_checker;
        logic [IP_W-1:0]   dest_tbl[ENTRIES];
        logic [IP_W-1:0]   mask_tbl[ENTRIES];
        logic [IP_W-1:0]   gw_tbl[ENTRIES];
        logic [PORT_W-1:0] port_tbl[ENTRIES];
        bit                valid_tbl[ENTRIES];
        route_result_t     owed_q[$];
        int                errors;
        int                writes;
        int                lookups;
        int                hits;
        int                misses;

        function new();
            foreach (valid_tbl[i])
                valid_tbl[i] = 1'b0;
            errors  = 0;
            writes  = 0;
            lookups = 0;
            hits    = 0;
            misses  = 0;
        endfunction

        // 32 minus trailing zeros, zero for an empty mask
        function int unsigned mask_length(logic [IP_W-1:0] m);
            int unsigned tz;
            tz = 0;
            if (m == '0)
                return 0;
            while (m[0] == 1'b0)
            begin
                m = m >> 1;
                tz++;
            end
            return 32 - tz;
        endfunction

        function void note_request(logic fn, logic [IN_W-1:0] d);
            logic [IDX_W-1:0]  idx;
            logic [IP_W-1:0]   addr;
            route_result_t     res;
            bit                found;
            int unsigned       len;
            idx  = d[3:0];
            addr = d[134:103];
            res  = '0;
            if (fn == FUNC_WRITE)
            begin
                writes++;
                if (idx < ENTRIES)
                begin
                    dest_tbl[idx]  = d[35:4];
                    mask_tbl[idx]  = d[67:36];
                    gw_tbl[idx]    = d[99:68];
                    port_tbl[idx]  = d[101:100];
                    valid_tbl[idx] = d[102];
                end
            end
            else
            begin
                lookups++;
                found = 1'b0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_tbl[i] && ((addr & mask_tbl[i]) == (dest_tbl[i] & mask_tbl[i])))
                    begin
                        len = mask_length(mask_tbl[i]);
                        // later slot wins a tie, hence >=
                        if (!found || len >= res.prefix_length)
                        begin
                            found             = 1'b1;
                            res.hit           = 1'b1;
                            res.next_hop      = gw_tbl[i];
                            res.out_port      = port_tbl[i];
                            res.prefix_length = len[PLEN_W-1:0];
                        end
                    end
                end
                if (found)
                    hits++;
                else
                    misses++;
            end
            owed_q.push_back(res);
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            route_result_t got;
            route_result_t exp_r;
            got = d[40:0];
            if (owed_q.size() == 0)
            begin
                $display("%0t: result with nothing owed, actual %h", $time, d);
                errors++;
                return;
            end
            exp_r = owed_q.pop_front();
            if (got.hit !== exp_r.hit)
            begin
                $display("%0t: hit expected %h actual %h", $time, exp_r.hit, got.hit);
                errors++;
            end
            if (got.next_hop !== exp_r.next_hop)
            begin
                $display("%0t: next_hop expected %h actual %h", $time, exp_r.next_hop,
                         got.next_hop);
                errors++;
            end
            if (got.out_port !== exp_r.out_port)
            begin
                $display("%0t: out_port expected %h actual %h", $time, exp_r.out_port,
                         got.out_port);
                errors++;
            end
            if (got.prefix_length !== exp_r.prefix_length)
            begin
                $display("%0t: prefix_length expected %0d actual %0d", $time,
                         exp_r.prefix_length, got.prefix_length);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    // entry_index, entry_dest, entry_mask, entry_gateway, entry_port,
    // entry_valid, lookup_address, one zero pad bit
    logic [IN_W-1:0]   s_axis_tdata;
    // func
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    // hit, next_hop, out_port, prefix_length, seven zero pad bits
    logic [OUT_W-1:0]  m_axis_tdata;

    route_checker      route_sb;
    bit                steady_phase;

    route_longest_prefix_match_core #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("route_longest_prefix_match_core: mismatch");
        $finish;
    end

    // both handshakes are observed on the same edge, request first
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                route_sb.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                route_sb.check_result(m_axis_tdata);
        end
    end

    // receiver: runs of full speed, short stalls and the odd long stall
    initial
    begin
        int pick;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            pick = $urandom_range(9);
            if (pick < 3)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(15, 50)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    function automatic logic [IP_W-1:0] prefix_mask(int len);
        if (len == 0)
            return '0;
        return {IP_W{1'b1}} << (32 - len);
    endfunction

    // mostly contiguous masks, some arbitrary bit patterns
    function automatic logic [IP_W-1:0] pick_mask();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 80)
            return prefix_mask($urandom_range(1, 32));
        return $urandom;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady_phase || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // presents one request and holds it until accepted; valid stays high
    // across back-to-back requests
    task automatic send_request(logic fn, logic [IN_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // route write, lookup address field filled with noise
    task automatic write_route(logic [IDX_W-1:0] idx, logic [IP_W-1:0] dest,
                               logic [IP_W-1:0] mask, logic [IP_W-1:0] gw,
                               logic [PORT_W-1:0] port, logic vld);
        logic [IP_W-1:0] noise;
        noise = $urandom;
        send_request(FUNC_WRITE, {1'b0, noise, vld, port, gw, mask, dest, idx});
    endtask

    // lookup, entry fields filled with noise
    task automatic lookup_route(logic [IP_W-1:0] addr);
        logic [102:0] noise;
        noise = 103'({$urandom, $urandom, $urandom, $urandom});
        send_request(FUNC_LOOKUP, {1'b0, addr, noise});
    endtask

    initial
    begin
        int               r;
        int               k;
        logic [IP_W-1:0]  addr;
        route_sb      = new();
        steady_phase  = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= FUNC_WRITE;
        s_axis_tdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table misses everything
        lookup_route(32'h0000_0000);
        lookup_route(32'hffff_ffff);
        // default route matches any address at length zero
        write_route(4'd0, 32'h0000_0000, 32'h0000_0000, 32'h0a00_0001, 2'd1, 1'b1);
        lookup_route(32'h1234_5678);
        // host route in the top slot, all ones everywhere
        write_route(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 2'd3, 1'b1);
        lookup_route(32'hffff_ffff);
        // nested /16 and /24, longer one wins
        write_route(4'd3, 32'hc0a8_0000, 32'hffff_0000, 32'hc0a8_0001, 2'd2, 1'b1);
        write_route(4'd4, 32'hc0a8_0100, 32'hffff_ff00, 32'hc0a8_0101, 2'd0, 1'b1);
        lookup_route(32'hc0a8_0142);
        lookup_route(32'hc0a8_ff01);
        // equal length in a later slot takes over
        write_route(4'd9, 32'hc0a8_5500, 32'hffff_0000, 32'h0b00_0001, 2'd3, 1'b1);
        lookup_route(32'hc0a8_0203);
        // removed slot keeps its contents but is skipped
        write_route(4'd9, 32'hc0a8_5500, 32'hffff_0000, 32'h0b00_0001, 2'd3, 1'b0);
        lookup_route(32'hc0a8_0203);
        // non-contiguous mask, length from trailing zeros only
        write_route(4'd6, 32'h0a00_0a00, 32'hff00_ff00, 32'h0102_0304, 2'd1, 1'b1);
        lookup_route(32'h0a7f_0aff);
        // drop the default route, then a plain miss
        write_route(4'd0, 32'h0000_0000, 32'h0000_0000, 32'h0a00_0001, 2'd1, 1'b0);
        lookup_route(32'h0808_0808);
        // hit whose payload is all zero
        write_route(4'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 2'd0, 1'b1);
        lookup_route(32'h0101_0101);
        // single-bit prefix
        write_route(4'd2, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 2'd3, 1'b1);
        lookup_route(32'hfedc_ba98);

        // random mix, lookups mostly aimed inside stored routes
        for (int n = 0; n < RANDOM_N; n++)
        begin
            if (n % 100 == 0)
                steady_phase = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < 25)
            begin
                write_route(IDX_W'($urandom), $urandom, pick_mask(), $urandom,
                            PORT_W'($urandom), $urandom_range(99) < 85);
            end
            else
            begin
                k = $urandom_range(ENTRIES - 1);
                if (r < 85 && route_sb.valid_tbl[k])
                    addr = (route_sb.dest_tbl[k] & route_sb.mask_tbl[k]) |
                           ($urandom & ~route_sb.mask_tbl[k]);
                else if (r < 88)
                    addr = '0;
                else if (r < 91)
                    addr = '1;
                else
                    addr = $urandom;
                lookup_route(addr);
            end
        end
        s_axis_tvalid <= 1'b0;

        // let the last request be noted before waiting for its result
        @(negedge clk);
        while (route_sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("run covered %0d route writes and %0d lookups (%0d hits, %0d misses)",
                 route_sb.writes, route_sb.lookups, route_sb.hits, route_sb.misses);
        $display("with random gaps on requests and random stalls on results");
        if (route_sb.errors == 0)
            $display("route_longest_prefix_match_core: match");
        else
            $display("route_longest_prefix_match_core: mismatch");
        $finish;
    end

endmodule
